FILE: src/hps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg
// Shared constants and types for the holonomic pose step pipeline.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int ANGLE_BITS        = 16;
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int ATAN_LEN          = 24;

    // CORDIC start vector, Q1.30, pre-scaled by the inverse rotator gain
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [32:0] QUARTER_TURN    = 33'sh040000000;
    localparam logic signed [32:0] HALF_TURN       = 33'sh080000000;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // configuration register indexes
    localparam logic [1:0] CFG_POS_GAIN  = 2'd0;
    localparam logic [1:0] CFG_HEAD_GAIN = 2'd1;
    localparam logic [1:0] CFG_LIN_LIM   = 2'd2;
    localparam logic [1:0] CFG_ANG_LIM   = 2'd3;

    // sideband that travels beside the first rotator
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [16:0] err;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [15:0] ch;
        logic [15:0]        dt;
    } t_sb1;

    // sideband that travels beside the second rotator
    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [15:0] heading;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [20:0] wr;
    } t_sb2;

endpackage

FILE: src/hps_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_cordic
// Pipelined rotation-mode CORDIC: one micro-rotation per stage, Q1.30 output.
// ----------------------------------------------------------------------------
module hps_cordic #(
    parameter int STEPS = hps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic [STEPS+1:0]    i_en,
    input  logic [31:0]         i_turn,
    output logic signed [31:0]  o_sin,
    output logic signed [31:0]  o_cos
);
    import hps_pkg::*;

    localparam int LAST = STEPS + 1;

    logic signed [32:0] r_x [STEPS+1];
    logic signed [32:0] r_y [STEPS+1];
    logic signed [32:0] r_a [STEPS+1];
    logic               r_flip [STEPS+1];
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;
    logic signed [32:0] w_turn;
    logic signed [32:0] n_a0;
    logic               n_flip0;

    assign w_turn = $signed({i_turn[31], i_turn});

    // fold into the right half plane, flip the result back at the end
    always_comb begin
        n_a0    = w_turn;
        n_flip0 = 1'b0;
        if (w_turn > QUARTER_TURN) begin
            n_a0    = w_turn - HALF_TURN;
            n_flip0 = 1'b1;
        end else if (w_turn < -QUARTER_TURN) begin
            n_a0    = w_turn + HALF_TURN;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= CORDIC_GAIN_Q30;
            r_y[0]    <= '0;
            r_a[0]    <= n_a0;
            r_flip[0] <= n_flip0;
        end
    end

    for (genvar j = 1; j <= STEPS; j++) begin : g_iter
        localparam int SH = j - 1;
        logic signed [32:0] w_xs;
        logic signed [32:0] w_ys;
        logic signed [32:0] w_at;
        assign w_xs = r_x[j-1] >>> SH;
        assign w_ys = r_y[j-1] >>> SH;
        assign w_at = $signed({1'b0, ATAN_TURN[SH]});
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                if (!r_a[j-1][32]) begin
                    r_x[j] <= r_x[j-1] - w_ys;
                    r_y[j] <= r_y[j-1] + w_xs;
                    r_a[j] <= r_a[j-1] - w_at;
                end else begin
                    r_x[j] <= r_x[j-1] + w_ys;
                    r_y[j] <= r_y[j-1] - w_xs;
                    r_a[j] <= r_a[j-1] + w_at;
                end
                r_flip[j] <= r_flip[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[LAST]) begin
            r_sin <= r_flip[STEPS] ? 32'(-r_y[STEPS]) : 32'(r_y[STEPS]);
            r_cos <= r_flip[STEPS] ? 32'(-r_x[STEPS]) : 32'(r_x[STEPS]);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: src/holonomic_pose_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// holonomic_pose_step_top
// Proportional holonomic pose controller with one Euler integration step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a target pose, the
//   current pose and a time step; one transfer per item. The output channel
//   (o_out_valid / i_out_ready) returns the next pose, the half-angle
//   quaternion (z, w) and the clamped commanded velocities, one transfer per
//   item, in order.
//   Throughput: one item per cycle while the receiver accepts results. The
//   data passes two rotator pipelines of CORDIC_STEPS + 2 stages each,
//   eight multiply/round stages and one output register.
//   Each stage has its own valid bit; a stage advances when it is empty or
//   the stage after it advances, so a stalled receiver holds the results and
//   empty stages still fill behind it. Nothing is dropped or repeated.
//   Configuration: write channel (i_cfg_valid / o_cfg_ready, always ready)
//   with a 2-bit register index and 24-bit data; write only while idle.
//   Reset (i_rst_n low, synchronous) clears all valid bits and loads the
//   gains to 1.0 and the default speed limits.
// ----------------------------------------------------------------------------
module holonomic_pose_step_top #(
    parameter int CORDIC_STEPS = hps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [15:0]  i_target_heading,
    input  logic signed [31:0]  i_current_x,
    input  logic signed [31:0]  i_current_y,
    input  logic signed [15:0]  i_current_heading,
    input  logic [15:0]         i_time_step,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_next_x,
    output logic signed [31:0]  o_next_y,
    output logic signed [15:0]  o_next_heading,
    output logic signed [15:0]  o_next_quat_z,
    output logic signed [15:0]  o_next_quat_w,
    output logic signed [23:0]  o_cmd_vx,
    output logic signed [23:0]  o_cmd_vy,
    output logic signed [20:0]  o_cmd_yaw_rate,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import hps_pkg::*;

    localparam int N      = CORDIC_STEPS;
    localparam int C1_END = N + 1;       // last stage of the first rotator
    localparam int M1     = N + 2;       // first multiply/round stage
    localparam int C2_BEG = N + 10;      // first stage of the second rotator
    localparam int C2_END = 2 * N + 11;
    localparam int OUTS   = 2 * N + 12;  // output register
    localparam int DEPTH  = 2 * N + 13;

    // ---------------- configuration registers ----------------
    logic [23:0] r_pos_gain;
    logic [23:0] r_head_gain;
    logic [22:0] r_lin_lim;
    logic [19:0] r_ang_lim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_gain  <= 24'd65536;
            r_head_gain <= 24'd65536;
            r_lin_lim   <= 23'd16384;
            r_ang_lim   <= 20'd8192;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POS_GAIN:  r_pos_gain  <= i_cfg_data;
                CFG_HEAD_GAIN: r_head_gain <= i_cfg_data;
                CFG_LIN_LIM:   r_lin_lim   <= i_cfg_data[22:0];
                CFG_ANG_LIM:   r_ang_lim   <= i_cfg_data[19:0];
                default:       r_pos_gain  <= r_pos_gain;
            endcase
        end
    end

    // ---------------- stage valids and advance enables ----------------
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic [DEPTH-1:0] w_en;

    // a stage advances when it is empty or its successor advances
    assign w_en[DEPTH-1] = !r_vld[DEPTH-1] || i_out_ready;
    for (genvar k = 0; k < DEPTH - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign n_vld = {r_vld[DEPTH-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[OUTS];

    // ---------------- entry: errors, first rotator ----------------
    t_sb1               r_sb1 [N+2];
    t_sb1               n_sb1;
    logic signed [17:0] w_err;
    logic signed [31:0] w_c;
    logic signed [31:0] w_s;

    // wrap the heading error to half a turn; exactly half a turn stays put
    always_comb begin
        w_err    = 18'($signed({i_target_heading[15], i_target_heading}))
                 - 18'($signed({i_current_heading[15], i_current_heading}));
        if (w_err > 18'sd32768)  w_err = w_err - 18'sd65536;
        if (w_err < -18'sd32768) w_err = w_err + 18'sd65536;
        n_sb1.dx  = $signed({i_target_x[31], i_target_x})
                  - $signed({i_current_x[31], i_current_x});
        n_sb1.dy  = $signed({i_target_y[31], i_target_y})
                  - $signed({i_current_y[31], i_current_y});
        n_sb1.err = w_err[16:0];
        n_sb1.cx  = i_current_x;
        n_sb1.cy  = i_current_y;
        n_sb1.ch  = i_current_heading;
        n_sb1.dt  = i_time_step;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_sb1[0] <= n_sb1;
        for (int k = 1; k <= C1_END; k++) begin
            if (w_en[k]) r_sb1[k] <= r_sb1[k-1];
        end
    end

    hps_cordic #(.STEPS(N)) u_rot_head (
        .i_clk  (i_clk),
        .i_en   (w_en[C1_END:0]),
        .i_turn ({i_current_heading, 16'h0000}),
        .o_sin  (w_s),
        .o_cos  (w_c)
    );

    // ---------------- M1: body-frame products ----------------
    logic signed [64:0] r_m1_dxc, r_m1_dys, r_m1_dyc, r_m1_dxs;
    logic signed [31:0] r_m1_c, r_m1_s;
    t_sb1               r_m1_sb;

    always_ff @(posedge i_clk) begin
        if (w_en[M1]) begin
            r_m1_dxc <= 65'(r_sb1[C1_END].dx * w_c);
            r_m1_dys <= 65'(r_sb1[C1_END].dy * w_s);
            r_m1_dyc <= 65'(r_sb1[C1_END].dy * w_c);
            r_m1_dxs <= 65'(r_sb1[C1_END].dx * w_s);
            r_m1_c   <= w_c;
            r_m1_s   <= w_s;
            r_m1_sb  <= r_sb1[C1_END];
        end
    end

    // ---------------- M2: round body error, heading product ----------------
    logic signed [65:0] w_m2_rx, w_m2_ry;
    logic signed [35:0] r_m2_rx, r_m2_ry;
    logic signed [41:0] r_m2_pw;
    logic signed [31:0] r_m2_c, r_m2_s;
    t_sb1               r_m2_sb;

    assign w_m2_rx = (66'(r_m1_dxc) + 66'(r_m1_dys) + (66'sd1 <<< 29)) >>> 30;
    assign w_m2_ry = (66'(r_m1_dyc) - 66'(r_m1_dxs) + (66'sd1 <<< 29)) >>> 30;

    always_ff @(posedge i_clk) begin
        if (w_en[M1+1]) begin
            r_m2_rx <= w_m2_rx[35:0];
            r_m2_ry <= w_m2_ry[35:0];
            r_m2_pw <= 42'($signed({1'b0, r_head_gain}) * r_m1_sb.err);
            r_m2_c  <= r_m1_c;
            r_m2_s  <= r_m1_s;
            r_m2_sb <= r_m1_sb;
        end
    end

    // ---------------- M3: position products, clamp yaw rate ----------------
    logic signed [60:0] r_m3_pvx, r_m3_pvy;
    logic signed [20:0] r_m3_wr;
    logic signed [31:0] r_m3_c, r_m3_s;
    t_sb1               r_m3_sb;
    logic signed [41:0] w_m3_wr;
    logic signed [20:0] n_m3_wr;
    logic signed [41:0] w_ang_lim;

    assign w_m3_wr   = (r_m2_pw + (42'sd1 <<< 15)) >>> 16;
    assign w_ang_lim = $signed({22'b0, r_ang_lim});

    always_comb begin
        n_m3_wr = w_m3_wr[20:0];
        if (w_m3_wr > w_ang_lim)  n_m3_wr = w_ang_lim[20:0];
        if (w_m3_wr < -w_ang_lim) n_m3_wr = 21'(-w_ang_lim);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[M1+2]) begin
            r_m3_pvx <= 61'($signed({1'b0, r_pos_gain}) * r_m2_rx);
            r_m3_pvy <= 61'($signed({1'b0, r_pos_gain}) * r_m2_ry);
            r_m3_wr  <= n_m3_wr;
            r_m3_c   <= r_m2_c;
            r_m3_s   <= r_m2_s;
            r_m3_sb  <= r_m2_sb;
        end
    end

    // ---------------- M4: clamp linear velocity, yaw step product ----------------
    logic signed [60:0] w_m4_vx, w_m4_vy, w_lin_lim;
    logic signed [23:0] n_m4_vx, n_m4_vy;
    logic signed [23:0] r_m4_vx, r_m4_vy;
    logic signed [20:0] r_m4_wr;
    logic signed [37:0] r_m4_pyaw;
    logic signed [31:0] r_m4_c, r_m4_s;
    t_sb1               r_m4_sb;

    assign w_m4_vx   = (r_m3_pvx + (61'sd1 <<< 15)) >>> 16;
    assign w_m4_vy   = (r_m3_pvy + (61'sd1 <<< 15)) >>> 16;
    assign w_lin_lim = $signed({38'b0, r_lin_lim});

    always_comb begin
        n_m4_vx = w_m4_vx[23:0];
        if (w_m4_vx > w_lin_lim)  n_m4_vx = w_lin_lim[23:0];
        if (w_m4_vx < -w_lin_lim) n_m4_vx = 24'(-w_lin_lim);
        n_m4_vy = w_m4_vy[23:0];
        if (w_m4_vy > w_lin_lim)  n_m4_vy = w_lin_lim[23:0];
        if (w_m4_vy < -w_lin_lim) n_m4_vy = 24'(-w_lin_lim);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[M1+3]) begin
            r_m4_vx   <= n_m4_vx;
            r_m4_vy   <= n_m4_vy;
            r_m4_wr   <= r_m3_wr;
            r_m4_pyaw <= 38'(r_m3_wr * $signed({1'b0, r_m3_sb.dt}));
            r_m4_c    <= r_m3_c;
            r_m4_s    <= r_m3_s;
            r_m4_sb   <= r_m3_sb;
        end
    end

    // ---------------- M5: world-frame products, new yaw ----------------
    logic signed [55:0] r_m5_vxc, r_m5_vys, r_m5_vxs, r_m5_vyc;
    logic signed [16:0] r_m5_yaw;
    logic signed [23:0] r_m5_vx, r_m5_vy;
    logic signed [20:0] r_m5_wr;
    t_sb1               r_m5_sb;
    logic signed [37:0] w_m5_dyaw;

    assign w_m5_dyaw = (r_m4_pyaw + (38'sd1 <<< 15)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (w_en[M1+4]) begin
            r_m5_vxc <= 56'(r_m4_vx * r_m4_c);
            r_m5_vys <= 56'(r_m4_vy * r_m4_s);
            r_m5_vxs <= 56'(r_m4_vx * r_m4_s);
            r_m5_vyc <= 56'(r_m4_vy * r_m4_c);
            // keep the yaw modulo two turns for the half-angle rotation
            r_m5_yaw <= 17'($signed({r_m4_sb.ch[15], r_m4_sb.ch}) + 17'(w_m5_dyaw));
            r_m5_vx  <= r_m4_vx;
            r_m5_vy  <= r_m4_vy;
            r_m5_wr  <= r_m4_wr;
            r_m5_sb  <= r_m4_sb;
        end
    end

    // ---------------- M6: round world velocity ----------------
    logic signed [56:0] w_m6_wx, w_m6_wy;
    logic signed [26:0] r_m6_wx, r_m6_wy;
    logic signed [16:0] r_m6_yaw;
    logic signed [23:0] r_m6_vx, r_m6_vy;
    logic signed [20:0] r_m6_wr;
    t_sb1               r_m6_sb;

    assign w_m6_wx = (57'(r_m5_vxc) - 57'(r_m5_vys) + (57'sd1 <<< 29)) >>> 30;
    assign w_m6_wy = (57'(r_m5_vxs) + 57'(r_m5_vyc) + (57'sd1 <<< 29)) >>> 30;

    always_ff @(posedge i_clk) begin
        if (w_en[M1+5]) begin
            r_m6_wx  <= w_m6_wx[26:0];
            r_m6_wy  <= w_m6_wy[26:0];
            r_m6_yaw <= r_m5_yaw;
            r_m6_vx  <= r_m5_vx;
            r_m6_vy  <= r_m5_vy;
            r_m6_wr  <= r_m5_wr;
            r_m6_sb  <= r_m5_sb;
        end
    end

    // ---------------- M7: position step products ----------------
    logic signed [43:0] r_m7_px, r_m7_py;
    logic signed [16:0] r_m7_yaw;
    logic signed [23:0] r_m7_vx, r_m7_vy;
    logic signed [20:0] r_m7_wr;
    logic signed [31:0] r_m7_cx, r_m7_cy;

    always_ff @(posedge i_clk) begin
        if (w_en[M1+6]) begin
            r_m7_px  <= 44'(r_m6_wx * $signed({1'b0, r_m6_sb.dt}));
            r_m7_py  <= 44'(r_m6_wy * $signed({1'b0, r_m6_sb.dt}));
            r_m7_yaw <= r_m6_yaw;
            r_m7_vx  <= r_m6_vx;
            r_m7_vy  <= r_m6_vy;
            r_m7_wr  <= r_m6_wr;
            r_m7_cx  <= r_m6_sb.cx;
            r_m7_cy  <= r_m6_sb.cy;
        end
    end

    // ---------------- M8: integrate position ----------------
    logic signed [43:0] w_m8_sx, w_m8_sy;
    logic signed [16:0] r_m8_yaw;
    t_sb2               r_m8_sb;

    assign w_m8_sx = (r_m7_px + (44'sd1 <<< 15)) >>> 16;
    assign w_m8_sy = (r_m7_py + (44'sd1 <<< 15)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (w_en[M1+7]) begin
            r_m8_sb.nx      <= r_m7_cx + w_m8_sx[31:0];
            r_m8_sb.ny      <= r_m7_cy + w_m8_sy[31:0];
            r_m8_sb.heading <= r_m7_yaw[15:0];
            r_m8_sb.vx      <= r_m7_vx;
            r_m8_sb.vy      <= r_m7_vy;
            r_m8_sb.wr      <= r_m7_wr;
            r_m8_yaw        <= r_m7_yaw;
        end
    end

    // ---------------- second rotator: half of the new yaw ----------------
    t_sb2               r_sb2 [N+2];
    logic signed [31:0] w_qs, w_qc;

    always_ff @(posedge i_clk) begin
        if (w_en[C2_BEG]) r_sb2[0] <= r_m8_sb;
        for (int k = 1; k <= N + 1; k++) begin
            if (w_en[C2_BEG+k]) r_sb2[k] <= r_sb2[k-1];
        end
    end

    hps_cordic #(.STEPS(N)) u_rot_quat (
        .i_clk  (i_clk),
        .i_en   (w_en[C2_END:C2_BEG]),
        .i_turn ({r_m8_yaw, 15'h0000}),
        .o_sin  (w_qs),
        .o_cos  (w_qc)
    );

    // ---------------- output register: round and clamp to Q1.14 ----------------
    logic signed [31:0] w_qz, w_qw;
    logic signed [15:0] n_qz, n_qw;

    assign w_qz = (w_qs + (32'sd1 <<< 15)) >>> 16;
    assign w_qw = (w_qc + (32'sd1 <<< 15)) >>> 16;

    always_comb begin
        n_qz = w_qz[15:0];
        if (w_qz > 32'sd16384)  n_qz = 16'sd16384;
        if (w_qz < -32'sd16384) n_qz = -16'sd16384;
        n_qw = w_qw[15:0];
        if (w_qw > 32'sd16384)  n_qw = 16'sd16384;
        if (w_qw < -32'sd16384) n_qw = -16'sd16384;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[OUTS]) begin
            o_next_x       <= r_sb2[N+1].nx;
            o_next_y       <= r_sb2[N+1].ny;
            o_next_heading <= r_sb2[N+1].heading;
            o_next_quat_z  <= n_qz;
            o_next_quat_w  <= n_qw;
            o_cmd_vx       <= r_sb2[N+1].vx;
            o_cmd_vy       <= r_sb2[N+1].vy;
            o_cmd_yaw_rate <= r_sb2[N+1].wr;
        end
    end

    // ---------------- assertions ----------------
    // any empty stage must let a new item in
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> o_in_ready)
        else $error("input stalled with an empty stage");

    // quaternion components stay within unit range
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_next_quat_z <= 16'sd16384 && o_next_quat_z >= -16'sd16384
                      && o_next_quat_w <= 16'sd16384 && o_next_quat_w >= -16'sd16384))
        else $error("quaternion component out of range");

    // a held result does not move while the receiver stalls
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_next_x)
                                        && $stable(o_cmd_yaw_rate))
        else $error("result changed during stall");

endmodule
